FILE: hdl/zvd_pkg.sv
// zvd_pkg: shared widths and constants for the zig-zag varint decoder
// no dependencies; imported by zigzag_varint_decoder
package zvd_pkg;

  // default and legal range of the longest encoding in bytes
  localparam int ZVD_MAX_BYTES     = 9;
  localparam int ZVD_MAX_BYTES_MIN = 2;
  localparam int ZVD_MAX_BYTES_MAX = 10;

  // field widths
  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 64;
  localparam int IDX_W   = 4;
  localparam int SHIFT_W = 6;

  // payload bits per byte and the continuation flag
  localparam int PAYLOAD_BITS = 7;
  localparam int CONT_BIT     = 7;

  typedef logic [VALUE_W-1:0] acc_t;
  typedef logic [IDX_W-1:0]   idx_t;

  // zig-zag decode: (t >> 1) xor -(t and 1)
  function automatic acc_t zigzag_decode(input acc_t t);
    zigzag_decode = (t >> 1) ^ {VALUE_W{t[0]}};
  endfunction

endpackage

FILE: hdl/zigzag_varint_decoder.sv
// zigzag_varint_decoder: streaming zig-zag LEB128 decoder, one byte per item
// depends on zvd_pkg
//
// Takes one byte per cycle and sustains one item per clock when the output
// side does not stall. An item waits in the input register, where the
// accumulate and decode logic works on it, and moves into the result
// register once that register is free. A byte that ends no value, or that is
// absorbed after a value ended, leaves the input register even while the
// result register is held. An empty-array mark or an array that ends
// mid-value yields an error result with value and byte_count zero.
// MAX_BYTES (2 to 10) sets the longest encoding; its final byte is taken
// whole as payload, continuation bit included.
module zigzag_varint_decoder #(
  parameter int MAX_BYTES = zvd_pkg::ZVD_MAX_BYTES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [zvd_pkg::BYTE_W-1:0]        data_byte,
  input  logic                              last_in_array,
  input  logic                              empty_array,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [zvd_pkg::VALUE_W-1:0] value,
  output logic [zvd_pkg::IDX_W-1:0]         byte_count,
  output logic                              error
);
  import zvd_pkg::*;

  localparam idx_t LAST_IDX = IDX_W'(MAX_BYTES - 1);

  // input register
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_last;
  logic              s1_empty;

  // decode state
  acc_t accumulator;
  acc_t accumulator_next;
  idx_t byte_index;
  idx_t byte_index_next;
  logic skipping_rest;
  logic skipping_rest_next;

  // single-pass decode results
  logic [SHIFT_W-1:0] shift;
  acc_t               byte_bits;
  acc_t               acc_merged;
  logic               done;
  logic               has_result;
  acc_t               res_value;
  idx_t               res_count;
  logic               res_error;

  logic out_free;
  logic s1_go;
  logic in_take;

  // handshake
  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid && (!has_result || out_free);
  assign in_stall = s1_valid && !s1_go;
  assign in_take  = in_valid && !in_stall;

  // place this byte's bits at 7 times its index
  always_comb begin
    shift = SHIFT_W'(byte_index) * SHIFT_W'(PAYLOAD_BITS);
    if (byte_index >= LAST_IDX) begin
      byte_bits = acc_t'(s1_byte) << shift;
      done      = 1'b1;
    end else begin
      byte_bits = acc_t'(s1_byte[PAYLOAD_BITS-1:0]) << shift;
      done      = !s1_byte[CONT_BIT];
    end
    acc_merged = accumulator | byte_bits;
  end

  // next state and result for the item in the input register
  always_comb begin
    accumulator_next   = accumulator;
    byte_index_next    = byte_index;
    skipping_rest_next = skipping_rest;
    has_result         = 1'b0;
    res_value          = '0;
    res_count          = '0;
    res_error          = 1'b0;
    if (s1_empty) begin
      accumulator_next   = '0;
      byte_index_next    = '0;
      skipping_rest_next = 1'b0;
      has_result         = 1'b1;
      res_error          = 1'b1;
    end else if (skipping_rest) begin
      if (s1_last) begin
        skipping_rest_next = 1'b0;
      end
    end else if (done) begin
      accumulator_next   = '0;
      byte_index_next    = '0;
      skipping_rest_next = !s1_last;
      has_result         = 1'b1;
      res_value          = zigzag_decode(acc_merged);
      res_count          = byte_index + idx_t'(1);
    end else if (s1_last) begin
      accumulator_next = '0;
      byte_index_next  = '0;
      has_result       = 1'b1;
      res_error        = 1'b1;
    end else begin
      accumulator_next = acc_merged;
      byte_index_next  = byte_index + idx_t'(1);
    end
  end

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte  <= data_byte;
      s1_last  <= last_in_array;
      s1_empty <= empty_array;
    end
  end

  // decode state update
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      byte_index    <= '0;
      skipping_rest <= 1'b0;
    end else if (s1_go) begin
      accumulator   <= accumulator_next;
      byte_index    <= byte_index_next;
      skipping_rest <= skipping_rest_next;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (s1_go && has_result) begin
      value      <= res_value;
      byte_count <= res_count;
      error      <= res_error;
    end
  end

  // index never passes the final byte position
  assert property (@(posedge clk) disable iff (rst) byte_index <= LAST_IDX)
    else $error("byte_index beyond final byte position");

  // absorbing mode starts from a clean accumulator
  assert property (@(posedge clk) disable iff (rst)
    skipping_rest |-> (accumulator == '0 && byte_index == '0))
    else $error("stale accumulator while absorbing");

  // error results carry zero value and count
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (value == '0 && byte_count == '0))
    else $error("error result with nonzero payload");

  // value results count between one and the longest encoding
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !error) |-> (byte_count != '0 && byte_count <= IDX_W'(MAX_BYTES)))
    else $error("byte_count out of range");

  // a result leaves the input register only into a free result register
  assert property (@(posedge clk) disable iff (rst)
    (s1_go && has_result) |-> out_free)
    else $error("result overwrote a held result");

endmodule
